### rtl/core/ffa_pkg.sv
// Shared constants, types and codes for the first-fit heap allocator.
`default_nettype none
package ffa_pkg;

  localparam int unsigned MAX_BLOCKS   = 256;
  localparam int unsigned HEAP_BYTES   = 1048576;
  localparam int unsigned HEADER_BYTES = 12;
  localparam int unsigned ALIGN_BYTES  = 4;

  localparam int unsigned IDX_W  = $clog2(MAX_BLOCKS);
  localparam int unsigned CNT_W  = IDX_W + 1;
  localparam int unsigned OFS_W  = $clog2(HEAP_BYTES) + 1;
  localparam int unsigned REQ_W  = 21;
  localparam int unsigned SZ_W   = REQ_W + 1;
  localparam int unsigned SUM_W  = ((OFS_W > SZ_W) ? OFS_W : SZ_W) + 1;
  localparam int unsigned ADDR_W = 32;
  localparam int unsigned STAT_W = 3;
  localparam int unsigned PADDR_W = 3;

  localparam logic [ADDR_W-1:0] PAGE_MASK = 32'h0000_0FFF;

  typedef enum logic [0:0] {
    FUNC_ALLOC = 1'b0,
    FUNC_FREE  = 1'b1
  } func_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_NEW    = 3'd0,
    STAT_REUSE  = 3'd1,
    STAT_ZERO   = 3'd2,
    STAT_HEAP   = 3'd3,
    STAT_TABLE  = 3'd4
  } status_e;

  localparam logic [PADDR_W-1:0] REG_IMG_END = 3'd0;

  typedef struct packed {
    logic             free;
    logic [OFS_W-1:0] ofs;
    logic [OFS_W-1:0] size;
  } entry_t;

endpackage
`default_nettype wire

### rtl/core/ffa_table.sv
// Block table memory: one write port, one registered read port.
`default_nettype none
module ffa_table
  import ffa_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [IDX_W-1:0] waddr_i,
  input  wire entry_t           wdata_i,
  input  wire logic [IDX_W-1:0] raddr_i,
  output entry_t                rdata_o
);

  entry_t mem [MAX_BLOCKS];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

### rtl/core/ffa_match.sv
// Shared entry compare unit: fit test for allocate, offset match for release.
`default_nettype none
module ffa_match
  import ffa_pkg::*;
(
  input  wire func_e             func_i,
  input  wire entry_t            entry_i,
  input  wire logic [SZ_W-1:0]   sz_i,
  input  wire logic [ADDR_W-1:0] target_i,
  output logic                   hit_o
);

  logic fit;
  logic same;

  assign fit  = entry_i.free && ({{(SZ_W-OFS_W){1'b0}}, entry_i.size} >= sz_i);
  assign same = ({{(ADDR_W-OFS_W){1'b0}}, entry_i.ofs} == target_i);

  always_comb begin
    unique case (func_i)
      FUNC_ALLOC: hit_o = fit;
      FUNC_FREE:  hit_o = same;
      default:    hit_o = 1'b0;
    endcase
  end

endmodule
`default_nettype wire

### rtl/core/first_fit_heap_allocator.sv
// Top level: APB register, scan sequencer, carve logic and result register.
// Allocate scans the table for a reuse hit and, on a miss, carves a new block in the
// carve state; release scans for the matching block and gives no result.
// Zero size answers without a scan. The table scan reads one entry per cycle from
// the single read port, which sets the rate. Reset clears block count, break,
// the kernel end register and the sequencer; table contents need no clearing.
`default_nettype none
module first_fit_heap_allocator
  import ffa_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               func_i,
  input  wire logic [REQ_W-1:0]   request_size_i,
  input  wire logic [ADDR_W-1:0]  release_address_i,
  output logic                    result_valid_o,
  output logic [ADDR_W-1:0]       user_address_o,
  output logic [STAT_W-1:0]       status_o
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SCAN  = 3'b010,
    S_CARVE = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [ADDR_W-1:0] kend_q;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [OFS_W-1:0]  brk_q, brk_d;
  func_e             func_q, func_d;
  logic [SZ_W-1:0]   sz_q, sz_d;
  logic [ADDR_W-1:0] target_q, target_d;
  logic [CNT_W-1:0]  issue_q, issue_d;
  logic [CNT_W-1:0]  ridx_q, ridx_d;
  logic              rvld_q, rvld_d;
  logic              res_vld_q, res_vld_d;
  logic [ADDR_W-1:0] res_addr_q, res_addr_d;
  logic [STAT_W-1:0] res_stat_q, res_stat_d;

  logic [ADDR_W-1:0] base;
  logic [ADDR_W-1:0] base_hdr;
  logic [SZ_W-1:0]   req_sz;
  logic [SUM_W-1:0]  carve_end;
  logic              heap_over;
  logic              table_full;
  logic              apb_wr;

  logic              we;
  logic [IDX_W-1:0]  waddr;
  entry_t            wdata;
  entry_t            rdata;
  logic              hit;

  // APB register
  assign pready = 1'b1;
  assign apb_wr = psel && penable && pwrite;
  assign prdata = (paddr[PADDR_W-1] == REG_IMG_END[PADDR_W-1]) ? kend_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kend_q <= '0;
    end else if (apb_wr && (paddr[PADDR_W-1] == REG_IMG_END[PADDR_W-1])) begin
      kend_q <= pwdata;
    end
  end

  assign base     = (kend_q + PAGE_MASK) & ~PAGE_MASK;
  assign base_hdr = base + ADDR_W'(HEADER_BYTES);

  // round the request up to the alignment
  assign req_sz = ({1'b0, request_size_i} + SZ_W'(ALIGN_BYTES - 1))
                  & ~SZ_W'(ALIGN_BYTES - 1);

  assign carve_end  = SUM_W'(brk_q) + SUM_W'(HEADER_BYTES) + SUM_W'(sz_q);
  assign heap_over  = carve_end > SUM_W'(HEAP_BYTES);
  assign table_full = count_q >= CNT_W'(MAX_BLOCKS);

  assign busy = (state_q != S_IDLE);

  ffa_table u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (issue_q[IDX_W-1:0]),
    .rdata_o (rdata)
  );

  ffa_match u_match (
    .func_i   (func_q),
    .entry_i  (rdata),
    .sz_i     (sz_q),
    .target_i (target_q),
    .hit_o    (hit)
  );

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    brk_d      = brk_q;
    func_d     = func_q;
    sz_d       = sz_q;
    target_d   = target_q;
    issue_d    = issue_q;
    ridx_d     = ridx_q;
    rvld_d     = 1'b0;
    res_vld_d  = 1'b0;
    res_addr_d = res_addr_q;
    res_stat_d = res_stat_q;
    we         = 1'b0;
    waddr      = ridx_q[IDX_W-1:0];
    wdata      = rdata;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          func_d   = func_e'(func_i);
          sz_d     = req_sz;
          target_d = release_address_i - base_hdr;
          issue_d  = '0;
          if (func_e'(func_i) == FUNC_FREE) begin
            if (release_address_i != '0) begin
              state_d = S_SCAN;
            end
          end else if (request_size_i == '0) begin
            res_vld_d  = 1'b1;
            res_addr_d = '0;
            res_stat_d = STAT_ZERO;
          end else begin
            state_d = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        // keep one read in flight ahead of the compare
        if (issue_q < count_q) begin
          rvld_d  = 1'b1;
          ridx_d  = issue_q;
          issue_d = issue_q + CNT_W'(1);
        end
        if (rvld_q && hit) begin
          we         = 1'b1;
          wdata.free = (func_q == FUNC_FREE);
          state_d    = S_IDLE;
          if (func_q == FUNC_ALLOC) begin
            res_vld_d  = 1'b1;
            res_addr_d = base_hdr + ADDR_W'(rdata.ofs);
            res_stat_d = STAT_REUSE;
          end
        end else if (!rvld_q && (issue_q >= count_q)) begin
          state_d = (func_q == FUNC_ALLOC) ? S_CARVE : S_IDLE;
        end
      end

      S_CARVE: begin
        state_d   = S_IDLE;
        res_vld_d = 1'b1;
        if (heap_over) begin
          res_addr_d = '0;
          res_stat_d = STAT_HEAP;
        end else if (table_full) begin
          res_addr_d = '0;
          res_stat_d = STAT_TABLE;
        end else begin
          we         = 1'b1;
          waddr      = count_q[IDX_W-1:0];
          wdata.free = 1'b0;
          wdata.ofs  = brk_q;
          wdata.size = sz_q[OFS_W-1:0];
          count_d    = count_q + CNT_W'(1);
          brk_d      = carve_end[OFS_W-1:0];
          res_addr_d = base_hdr + ADDR_W'(brk_q);
          res_stat_d = STAT_NEW;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      brk_q     <= '0;
      rvld_q    <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      brk_q     <= brk_d;
      rvld_q    <= rvld_d;
      res_vld_q <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q     <= func_d;
    sz_q       <= sz_d;
    target_q   <= target_d;
    issue_q    <= issue_d;
    ridx_q     <= ridx_d;
    res_addr_q <= res_addr_d;
    res_stat_q <= res_stat_d;
  end

  assign result_valid_o = res_vld_q;
  assign user_address_o = res_addr_q;
  assign status_o       = res_stat_q;

endmodule
`default_nettype wire

### test/heap_tracker.sv
// Port monitor for the heap allocator: predicts every grant and checks it.
module heap_tracker
  import ffa_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  input  logic [31:0]        prdata,
  input  logic               pready,
  input  logic               start,
  input  logic               busy,
  input  logic               func_i,
  input  logic [REQ_W-1:0]   request_size_i,
  input  logic [ADDR_W-1:0]  release_address_i,
  input  logic               result_valid_o,
  input  logic [ADDR_W-1:0]  user_address_o,
  input  logic [STAT_W-1:0]  status_o,
  output int unsigned        pending_o,
  output int unsigned        fail_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    status_e           stat;
  } grant_t;

  // shadow of the block table and allocator registers
  logic [OFS_W-1:0]  blk_size [MAX_BLOCKS];
  logic [OFS_W-1:0]  blk_ofs  [MAX_BLOCKS];
  logic              blk_free [MAX_BLOCKS];
  int unsigned       blk_count;
  logic [31:0]       brk_ofs;
  logic [ADDR_W-1:0] img_end;

  grant_t      expected_grants[$];
  int unsigned fails = 0;

  assign fail_count_o = fails;

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t ns  %s: got %h, want %h", $time, what, got, want);
    fails++;
  endtask

  function automatic logic [ADDR_W-1:0] heap_start();
    return (img_end + PAGE_MASK) & ~PAGE_MASK;
  endfunction

  function automatic logic [ADDR_W-1:0] data_addr(int unsigned k);
    return heap_start() + ADDR_W'(blk_ofs[k]) + ADDR_W'(HEADER_BYTES);
  endfunction

  function automatic void release_block(logic [ADDR_W-1:0] addr);
    if (addr == '0) return;
    for (int k = 0; k < blk_count; k++) begin
      if (data_addr(k) == addr) begin
        blk_free[k] = 1'b1;
        return;
      end
    end
  endfunction

  function automatic grant_t grant_for(logic [REQ_W-1:0] req);
    grant_t      g;
    int unsigned sz;
    g.addr = '0;
    if (req == '0) begin
      g.stat = STAT_ZERO;
      return g;
    end
    sz = (int'(req) + ALIGN_BYTES - 1) / ALIGN_BYTES * ALIGN_BYTES;
    // first fit: reuse the lowest free block that is large enough, whole
    for (int k = 0; k < blk_count; k++) begin
      if (blk_free[k] && int'(blk_size[k]) >= sz) begin
        blk_free[k] = 1'b0;
        g.addr = data_addr(k);
        g.stat = STAT_REUSE;
        return g;
      end
    end
    if (brk_ofs + HEADER_BYTES + sz > HEAP_BYTES) begin
      g.stat = STAT_HEAP;
    end else if (blk_count >= MAX_BLOCKS) begin
      g.stat = STAT_TABLE;
    end else begin
      blk_size[blk_count] = OFS_W'(sz);
      blk_ofs[blk_count]  = OFS_W'(brk_ofs);
      blk_free[blk_count] = 1'b0;
      g.addr = data_addr(blk_count);
      g.stat = STAT_NEW;
      blk_count++;
      brk_ofs = brk_ofs + HEADER_BYTES + sz;
    end
    return g;
  endfunction

  always @(posedge clk_i) begin
    grant_t want;
    if (!rst_ni) begin
      img_end   = '0;
      blk_count = 0;
      brk_ofs   = '0;
      expected_grants.delete();
    end else begin
      // check the word leaving before predicting the one entering
      if (result_valid_o !== 1'b0) begin
        if (expected_grants.size() == 0) begin
          report_mismatch("result with no allocate pending", user_address_o, '0);
        end else begin
          want = expected_grants.pop_front();
          if (user_address_o !== want.addr)
            report_mismatch("user_address", user_address_o, want.addr);
          if (status_o !== want.stat)
            report_mismatch("status", 32'(status_o), 32'(want.stat));
        end
      end
      if (start && !busy) begin
        if (func_e'(func_i) == FUNC_FREE) release_block(release_address_i);
        else expected_grants.push_back(grant_for(request_size_i));
      end
      if (psel && penable && pready && paddr == REG_IMG_END) begin
        if (pwrite) img_end = pwdata;
        else if (prdata !== img_end) report_mismatch("image end readback", prdata, img_end);
      end
    end
    pending_o <= expected_grants.size();
  end

endmodule

### test/testbench.sv
// Top of the heap allocator bench: clock, reset, stimulus, watchdog and verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import ffa_pkg::*;

  localparam int unsigned CLK_PERIOD     = 10;
  localparam int unsigned RESET_CYCLES   = 12;
  localparam int unsigned DRAIN_CYCLES   = MAX_BLOCKS + 40;
  localparam int unsigned WATCHDOG_LIMIT = 4000;

  logic               clk_i             = 1'b0;
  logic               rst_ni            = 1'b0;
  logic               psel              = 1'b0;
  logic               penable           = 1'b0;
  logic               pwrite            = 1'b0;
  logic [PADDR_W-1:0] paddr             = REG_IMG_END;
  logic [31:0]        pwdata            = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               start             = 1'b0;
  logic               busy;
  logic               func_i            = FUNC_ALLOC;
  logic [REQ_W-1:0]   request_size_i    = '0;
  logic [ADDR_W-1:0]  release_address_i = '0;
  logic               result_valid_o;
  logic [ADDR_W-1:0]  user_address_o;
  logic [STAT_W-1:0]  status_o;
  int unsigned        pending;
  int unsigned        fail_count;

  // stimulus bookkeeping: granted data offsets from the heap start, sizes in flight
  logic [ADDR_W-1:0]  img_end_now = '0;
  logic [ADDR_W-1:0]  live_ofs[$];
  logic [REQ_W-1:0]   sizes_in_flight[$];
  int unsigned        heap_used = 0;
  int unsigned        burst_left = 0;
  int unsigned        idle_cycles = 0;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  first_fit_heap_allocator i_dut (
    .clk_i,
    .rst_ni,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready,
    .start,
    .busy,
    .func_i,
    .request_size_i,
    .release_address_i,
    .result_valid_o,
    .user_address_o,
    .status_o
  );

  heap_tracker i_tracker (
    .clk_i,
    .rst_ni,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready,
    .start,
    .busy,
    .func_i,
    .request_size_i,
    .release_address_i,
    .result_valid_o,
    .user_address_o,
    .status_o,
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  function automatic logic [ADDR_W-1:0] page_up(logic [ADDR_W-1:0] a);
    return (a + PAGE_MASK) & ~PAGE_MASK;
  endfunction

  // track grants so that releases can target live blocks
  always @(posedge clk_i) begin
    logic [REQ_W-1:0] sz;
    if (rst_ni && result_valid_o && sizes_in_flight.size() != 0) begin
      sz = sizes_in_flight.pop_front();
      if (status_e'(status_o) == STAT_NEW)
        heap_used += HEADER_BYTES + (int'(sz) + ALIGN_BYTES - 1) / ALIGN_BYTES * ALIGN_BYTES;
      if (status_e'(status_o) == STAT_NEW || status_e'(status_o) == STAT_REUSE)
        live_ofs.push_back(user_address_o - page_up(img_end_now));
    end
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || result_valid_o || (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("first_fit_heap_allocator: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic idle(int unsigned n);
    @(negedge clk_i);
    start <= 1'b0;
    repeat (n - 1) @(negedge clk_i);
  endtask

  task automatic send(func_e f, logic [REQ_W-1:0] sz, logic [ADDR_W-1:0] addr);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) idle($urandom_range(1, 16));
    end
    burst_left--;
    @(negedge clk_i);
    start             <= 1'b1;
    func_i            <= f;
    request_size_i    <= sz;
    release_address_i <= addr;
    do @(posedge clk_i); while (busy);
    if (f == FUNC_ALLOC) sizes_in_flight.push_back(sz);
  endtask

  task automatic request_block(int unsigned sz);
    send(FUNC_ALLOC, REQ_W'(sz), $urandom);
  endtask

  task automatic release_addr(logic [ADDR_W-1:0] addr);
    send(FUNC_FREE, REQ_W'($urandom_range(0, HEAP_BYTES)), addr);
  endtask

  task automatic release_live();
    int unsigned       idx;
    logic [ADDR_W-1:0] ofs;
    idx = $urandom_range(0, live_ofs.size() - 1);
    ofs = live_ofs[idx];
    // keep a few freed offsets around so that double releases happen
    if ($urandom_range(0, 4) != 0) live_ofs.delete(idx);
    release_addr(page_up(img_end_now) + ofs);
  endtask

  task automatic release_noise();
    case ($urandom_range(0, 2))
      0: release_addr('0);
      // data addresses sit on word boundaries, so this one never matches
      1: release_addr(page_up(img_end_now) + 4 * $urandom_range(0, 4096) + 2);
      default: release_addr($urandom);
    endcase
  endtask

  task automatic drain();
    @(negedge clk_i);
    start <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    // a release has no result: give the table scan time to finish
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_img_end(logic [ADDR_W-1:0] v);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_IMG_END;
    pwdata  <= v;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    img_end_now = v;
    // read it back straight away
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic run_directed();
    logic [ADDR_W-1:0] b;
    b = page_up(img_end_now);
    request_block(0);
    request_block(HEAP_BYTES);
    request_block(HEAP_BYTES - 3);
    request_block(1);
    request_block(2);
    request_block(3);
    request_block(4);
    request_block(5);
    release_addr('0);
    release_addr(b + HEADER_BYTES + 4);
    release_addr(b);
    release_addr(b + HEADER_BYTES);
    release_addr(b + HEADER_BYTES);
    request_block(8);
    request_block(3);
    release_addr(b + 64 + HEADER_BYTES);
    release_addr(b + 84 + HEADER_BYTES);
    request_block(6);
    request_block(7);
    // break is 104 here: rounding pushes this one four bytes past the heap end
    request_block(HEAP_BYTES - 104 - HEADER_BYTES + 1);
  endtask

  task automatic run_phase(int unsigned n, int unsigned rel_pct, int unsigned huge_pct,
                           int unsigned small_max);
    int unsigned pick;
    for (int unsigned k = 0; k < n; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 4) request_block(0);
      else if (pick < 10) release_noise();
      else if (pick < 10 + rel_pct) begin
        if (live_ofs.size() != 0) release_live();
        else release_noise();
      end else if (pick < 10 + rel_pct + huge_pct) request_block($urandom_range(4096, HEAP_BYTES));
      else request_block($urandom_range(1, small_max));
      if ($urandom_range(0, 99) == 0) drain();
    end
  endtask

  initial begin
    int unsigned room;
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;

    write_img_end(32'h0010_0001);
    run_directed();
    drain();
    // fill the table with small blocks first, then churn and exhaust the heap
    write_img_end(32'hFFFF_FFFF);
    run_phase(140, 3, 0, 64);
    drain();
    write_img_end(32'hFFFF_F001);
    run_phase(140, 8, 0, 64);
    drain();
    write_img_end($urandom);
    run_phase(120, 25, 0, 512);
    drain();
    write_img_end(32'h0000_0000);
    run_phase(110, 35, 8, 512);
    drain();
    write_img_end(32'hFFFF_F000);
    run_phase(100, 30, 10, 512);
    drain();

    // probe the heap end: one word too much, then an exact fit
    room = HEAP_BYTES - heap_used;
    if (room > HEADER_BYTES) begin
      request_block(room - HEADER_BYTES + 1);
      request_block(room - HEADER_BYTES);
    end
    drain();

    if (fail_count == 0) $display("first_fit_heap_allocator: match");
    else $display("first_fit_heap_allocator: mismatch");
    $finish;
  end

endmodule
